### design/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants and controller-to-datapath types of the tertile pivot
// selection unit.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned MaxElements = 512;
  localparam int unsigned CountW      = $clog2(MaxElements + 1);
  localparam int unsigned AddrW       = $clog2(MaxElements);
  localparam int unsigned ValueW      = 32;
  localparam int unsigned BitW        = $clog2(ValueW);

  // Exact floor(x / 3) as (x * DivThreeMul) >> DivThreeShift for x below 2**16.
  localparam int unsigned DivThreeShift = 17;
  localparam logic [DivThreeShift-1:0] DivThreeMul = DivThreeShift'(43691);

  typedef struct packed {
    logic store;
    logic latch_sel;
    logic calc;
    logic rd;
    logic decide;
    logic emit;
  } tps_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic bit_zero;
    logic out_busy;
  } tps_status_t;

endpackage

### design/tps_ctrl.sv
// ----------------------------------------------------------------------------
// tps_ctrl
// Sequencer of the tertile pivot selection unit: loading, index setup,
// one memory sweep per result bit, and hand-off to the output register.
// ----------------------------------------------------------------------------
module tps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tlast_i,
  output logic                 s_tready_o,
  input  tps_pkg::tps_status_t status_i,
  output tps_pkg::tps_cmd_t    cmd_o
);

  localparam logic [2:0] StLoad   = 3'd0;
  localparam logic [2:0] StCalc   = 3'd1;
  localparam logic [2:0] StRead   = 3'd2;
  localparam logic [2:0] StDrain  = 3'd3;
  localparam logic [2:0] StDecide = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      StLoad: begin
        s_tready_o      = 1'b1;
        cmd_o.store     = s_tvalid_i;
        cmd_o.latch_sel = s_tvalid_i & s_tlast_i;
        if (s_tvalid_i && s_tlast_i) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        if (status_i.addr_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = status_i.bit_zero ? StDone : StRead;
      end
      StDone: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/tps_datapath.sv
// ----------------------------------------------------------------------------
// tps_datapath
// Element memory, run counters and the bitwise radix selection that finds
// the requested order statistic, plus the result register.
// ----------------------------------------------------------------------------
module tps_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tps_pkg::tps_cmd_t            cmd_i,
  output tps_pkg::tps_status_t         status_o,
  input  logic [tps_pkg::ValueW-1:0]   value_i,
  input  logic                         sel_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [tps_pkg::ValueW-1:0]   pivot_o,
  output logic                         overflow_o
);

  localparam int unsigned CountW = tps_pkg::CountW;
  localparam int unsigned AddrW  = tps_pkg::AddrW;
  localparam int unsigned ValueW = tps_pkg::ValueW;
  localparam int unsigned BitW   = tps_pkg::BitW;
  localparam int unsigned XW     = CountW + 1;
  localparam int unsigned ProdW  = XW + tps_pkg::DivThreeShift;
  localparam logic [ValueW-1:0] SignFlip = {1'b1, {(ValueW-1){1'b0}}};

  logic [ValueW-1:0] mem_q [tps_pkg::MaxElements];

  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              sel_q;
  logic [AddrW-1:0]  rd_addr_q;
  logic [ValueW-1:0] rd_data_q;
  logic              rd_vld_q;
  logic [CountW-1:0] cnt_q;
  logic [CountW-1:0] k_q;
  logic [ValueW-1:0] prefix_q;
  logic [ValueW-1:0] mask_q;
  logic [BitW-1:0]   bit_q;
  logic              m_valid_q;
  logic [ValueW-1:0] pivot_q;
  logic              m_ovf_q;

  logic              full;
  logic [CountW-1:0] r_minus1;
  logic [XW-1:0]     div_x;
  logic [ProdW-1:0]  div_prod;
  logic [CountW-1:0] k_calc;
  logic [ValueW-1:0] key;
  logic              match;
  logic [ValueW-1:0] bit_onehot;

  assign full     = (count_q == CountW'(tps_pkg::MaxElements));
  assign r_minus1 = count_q - CountW'(1);
  assign div_x    = sel_q ? {r_minus1, 1'b0} : {1'b0, r_minus1};
  assign div_prod = ProdW'(div_x) * ProdW'(tps_pkg::DivThreeMul);

  always_comb begin
    k_calc = div_prod[tps_pkg::DivThreeShift +: CountW];
    if (sel_q && (count_q == CountW'(2))) begin
      k_calc = CountW'(1);
    end
  end

  assign key        = rd_data_q ^ SignFlip;
  assign match      = (((key ^ prefix_q) & mask_q) == '0) && !key[bit_q];
  assign bit_onehot = ValueW'(1) << bit_q;

  assign status_o.addr_last = ({1'b0, rd_addr_q} == r_minus1);
  assign status_o.bit_zero  = (bit_q == '0);
  assign status_o.out_busy  = m_valid_q & ~m_tready_i;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.emit) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.store) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem_q[count_q[AddrW-1:0]] <= value_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_sel) begin
      sel_q <= sel_i;
    end
    if (cmd_i.calc) begin
      k_q       <= k_calc;
      prefix_q  <= '0;
      mask_q    <= '0;
      bit_q     <= BitW'(ValueW - 1);
      rd_addr_q <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.decide) begin
      if (cnt_q <= k_q) begin
        prefix_q <= prefix_q | bit_onehot;
        k_q      <= k_q - cnt_q;
      end
      mask_q    <= mask_q | bit_onehot;
      bit_q     <= bit_q - BitW'(1);
      rd_addr_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.rd) begin
        rd_addr_q <= rd_addr_q + AddrW'(1);
      end
      if (rd_vld_q && match) begin
        cnt_q <= cnt_q + CountW'(1);
      end
    end
    if (cmd_i.emit) begin
      pivot_q <= prefix_q ^ SignFlip;
      m_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign pivot_o    = pivot_q;
  assign overflow_o = m_ovf_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(tps_pkg::MaxElements))
    else $error("Element count exceeds the store capacity.");

  a_read_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> ({1'b0, rd_addr_q} < count_q))
    else $error("Read address lies beyond the loaded run.");

  a_rank_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> (k_q < count_q) && (cnt_q <= count_q))
    else $error("Remaining rank is outside the loaded run.");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(m_valid_q && !m_tready_i))
    else $error("Result written while the previous one is still held.");
`endif

endmodule

### design/tertile_pivot_select_unit.sv
// ----------------------------------------------------------------------------
// tertile_pivot_select_unit
// Loads a run of signed values and returns its lower- or upper-third
// order statistic.
// ----------------------------------------------------------------------------
// The slave stream carries one signed 32-bit value per item; tlast marks the
// final item of a run and tuser, sampled with that item, selects the lower-
// third (0) or upper-third (1) pivot. Up to 512 values are kept; further
// items are accepted and dropped and the result flags overflow.
// While a run loads, one item is accepted every cycle, also while an earlier
// result still waits on the master side.
// After the last item the unit finds the result with a radix selection: one
// sweep over the element memory per result bit, at one read per cycle and
// one read per kept value in each sweep. No item is accepted during that
// time.
// The master stream then presents the pivot in tdata and the overflow flag
// in tuser, held in an output register until taken. If the receiver stalls,
// the next run loads normally, and its own result waits until the previous
// one has been taken.
// Reset empties the run and drops any pending result; memory contents are
// not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module tertile_pivot_select_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tuser_i,   // [0] pivot_select
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] pivot
  output logic        m_axis_tuser_o    // [0] overflow
);

  tps_pkg::tps_cmd_t    cmd;
  tps_pkg::tps_status_t status;

  tps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tps_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .value_i    (s_axis_tdata_i),
    .sel_i      (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .pivot_o    (m_axis_tdata_o),
    .overflow_o (m_axis_tuser_o)
  );

endmodule
